/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the sampler.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge and disabled in reset.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* rtl/rzps_pkg.sv */
// Types, constants and the angle table of the rotate-and-zoom sampler.
// Depends on nothing; used by the top level and its checker.
package rzps_pkg;

   localparam int POS_W           = 6;
   localparam int COLOR_W         = 4;
   localparam int CMD_W           = 2;
   localparam int CYCLE_W         = 8;
   localparam int STEP_W          = 11;
   localparam int FRAME_W         = 7;
   localparam int FRAMES_MAX      = 128;
   localparam int ZOOM_W          = 18;
   localparam int ZOOM_FRAC_BITS  = 16;
   localparam int ANGLE_W         = 32;
   localparam int ANGLE_FRAC_BITS = 30;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 11;

   localparam int SCREEN_SIZE_DEF     = 40;
   localparam int COEFF_FRAC_BITS_DEF = 14;

   localparam logic [CYCLE_W-1:0]       CYCLE_LENGTH_RST = 8'd128;
   localparam logic [CYCLE_W-1:0]       CYCLE_MAX        = 8'd128;
   localparam logic [STEP_W-1:0]        SCALE_STEP_RST   = 11'd524;
   localparam logic signed [ZOOM_W-1:0] ZOOM_ONE         = 18'sd65536;
   localparam logic signed [ZOOM_W-1:0] ZOOM_MIN         = -18'sd65536;

   localparam longint STEP_COS_Q30 = 64'sd1053131022;
   localparam longint STEP_SIN_Q30 = 64'sd209371810;

   localparam logic [CSR_INDEX_W-1:0] CSR_CYCLE_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_STEP   = 1'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD    = 2'd0,
      CMD_SAMPLE  = 2'd1,
      CMD_ADVANCE = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [COLOR_W-1:0] color;
   } item_type;

   typedef logic [FRAMES_MAX-1:0][ANGLE_W-1:0] angle_table_type;

   // Shift right with rounding of the magnitude, half away from zero.
   function automatic longint round_shift(input longint v, input int sh);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) <<< (sh - 1))) >>> sh;
      return (v < 0) ? -m : m;
   endfunction

   // Cosine or sine of k times the step angle, built by repeated rotation in Q1.30.
   function automatic angle_table_type build_angle_table(input logic want_sin);
      angle_table_type tab;
      longint          c;
      longint          s;
      longint          nc;
      longint          ns;
      int              k;
      c = longint'(1) <<< ANGLE_FRAC_BITS;
      s = 0;
      for (k = 0; k < FRAMES_MAX; k++) begin
         tab[k] = want_sin ? s[ANGLE_W-1:0] : c[ANGLE_W-1:0];
         nc = round_shift(c * STEP_COS_Q30 - s * STEP_SIN_Q30, ANGLE_FRAC_BITS);
         ns = round_shift(s * STEP_COS_Q30 + c * STEP_SIN_Q30, ANGLE_FRAC_BITS);
         c = nc;
         s = ns;
      end
      return tab;
   endfunction

endpackage

/* rtl/rotate_zoom_pixel_sampler.sv */
// Rotate-and-zoom pixel sampler: six register stages, the source image store and the
// output register. Depends on rzps_pkg.
//
// Channel  Dir  Handshake              Word
// req      in   req_valid / req_ready  command, pos_x, pos_y, load_color
// rsp      out  rsp_valid / rsp_ready  dest_x, dest_y, pixel_color
// csr      in   csr_write              csr_index, csr_wdata
//
// One word is accepted in every cycle while req_ready is high; a sample's result word is presented after stage six.
// Loads and samples meet the single-port image store in the last stage, so they stay in order.
// Frame words update the coefficients as they leave stage two, ahead of later samples.
// Reset clears control state and the frame registers; the image store is undefined until loaded.
// A stall holds each full stage and lets empty stages behind it fill.
module rotate_zoom_pixel_sampler
   import rzps_pkg::*;
#(
   parameter int SCREEN_SIZE     = SCREEN_SIZE_DEF,
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CMD_W-1:0]       req_command,
   input  logic [POS_W-1:0]       req_pos_x,
   input  logic [POS_W-1:0]       req_pos_y,
   input  logic [COLOR_W-1:0]     req_load_color,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [POS_W-1:0]       rsp_dest_x,
   output logic [POS_W-1:0]       rsp_dest_y,
   output logic [COLOR_W-1:0]     rsp_pixel_color,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CENTER   = SCREEN_SIZE / 2;
   localparam int COEFF_W  = COEFF_FRAC_BITS + 2;
   localparam int PROD_W   = ZOOM_W + ANGLE_W;
   localparam int ROUND_SH = ZOOM_FRAC_BITS + ANGLE_FRAC_BITS - COEFF_FRAC_BITS;
   localparam int DELTA_W  = POS_W + 1;
   localparam int MUL_W    = DELTA_W + COEFF_W;
   localparam int SUM_W    = MUL_W + 2;
   localparam int INT_W    = SUM_W - COEFF_FRAC_BITS;
   localparam int PIXELS   = SCREEN_SIZE * SCREEN_SIZE;
   localparam int ADDR_W   = $clog2(PIXELS);
   localparam int STAGES   = 6;

   localparam angle_table_type ANGLE_COS = build_angle_table(1'b0);
   localparam angle_table_type ANGLE_SIN = build_angle_table(1'b1);

   localparam logic signed [DELTA_W-1:0] CENTER_D      = DELTA_W'(CENTER);
   localparam logic signed [SUM_W-1:0]   OFFSET        = SUM_W'(longint'(CENTER)
                                                               <<< COEFF_FRAC_BITS);
   localparam logic signed [SUM_W-1:0]   TRUNC_BIAS    = SUM_W'((longint'(1)
                                                               <<< COEFF_FRAC_BITS) - 1);
   localparam logic signed [PROD_W-1:0]  ROUND_HALF    = PROD_W'(longint'(1)
                                                               <<< (ROUND_SH - 1));
   localparam logic signed [PROD_W-1:0]  ROUND_HALF_M1 = ROUND_HALF - PROD_W'(1);
   localparam logic signed [INT_W-1:0]   SIZE_I        = INT_W'(SCREEN_SIZE);
   localparam logic signed [COEFF_W-1:0] COEFF_ONE     = COEFF_W'(longint'(1)
                                                               <<< COEFF_FRAC_BITS);

   // Configuration and frame state.
   logic [CYCLE_W-1:0]        cycle_length_ff;
   logic [STEP_W-1:0]         scale_step_ff;
   logic [FRAME_W-1:0]        frame_ff;
   logic [FRAME_W-1:0]        frame_in;
   logic signed [ZOOM_W-1:0]  zoom_ff;
   logic signed [ZOOM_W-1:0]  zoom_in;
   logic signed [COEFF_W-1:0] coeff_cos_ff;
   logic signed [COEFF_W-1:0] coeff_sin_ff;
   logic signed [COEFF_W-1:0] coeff_cos_in;
   logic signed [COEFF_W-1:0] coeff_sin_in;
   logic [CYCLE_W-1:0]        cycle_len;
   logic [CYCLE_W-1:0]        frame_next;
   logic signed [ZOOM_W-1:0]  zoom_dec;
   logic                      advance_accept;
   logic                      coeff_load;

   // Pipeline control.
   logic [STAGES:1] valid_ff;
   logic [STAGES:1] move;
   logic            out_valid_ff;
   logic            out_move;
   item_type        item_ff [1:STAGES];
   item_type        item_in;

   // Stage payloads.
   logic [FRAME_W-1:0]        frame1_ff;
   logic signed [ZOOM_W-1:0]  zoom1_ff;
   logic signed [ANGLE_W-1:0] angle_cos1;
   logic signed [ANGLE_W-1:0] angle_sin1;
   logic signed [PROD_W-1:0]  pcos_in;
   logic signed [PROD_W-1:0]  psin_in;
   logic signed [PROD_W-1:0]  pcos2_ff;
   logic signed [PROD_W-1:0]  psin2_ff;
   logic signed [DELTA_W-1:0] dx_in;
   logic signed [DELTA_W-1:0] dy_in;
   logic signed [DELTA_W-1:0] dx2_ff;
   logic signed [DELTA_W-1:0] dy2_ff;
   logic signed [PROD_W-1:0]  rnd_cos;
   logic signed [PROD_W-1:0]  rnd_sin;
   logic signed [MUL_W-1:0]   mxc3_ff;
   logic signed [MUL_W-1:0]   mys3_ff;
   logic signed [MUL_W-1:0]   mxs3_ff;
   logic signed [MUL_W-1:0]   myc3_ff;
   logic signed [SUM_W-1:0]   sum_x_in;
   logic signed [SUM_W-1:0]   sum_y_in;
   logic signed [SUM_W-1:0]   sum_x4_ff;
   logic signed [SUM_W-1:0]   sum_y4_ff;
   logic signed [SUM_W-1:0]   trunc_x;
   logic signed [SUM_W-1:0]   trunc_y;
   logic signed [INT_W-1:0]   col_in;
   logic signed [INT_W-1:0]   row_in;
   logic signed [INT_W-1:0]   col5_ff;
   logic signed [INT_W-1:0]   row5_ff;
   logic                      inside_in;
   logic [ADDR_W-1:0]         addr_in;
   logic                      inside6_ff;
   logic [ADDR_W-1:0]         addr6_ff;
   logic                      inside_out_ff;
   logic [COLOR_W-1:0]        read_color_ff;
   logic [POS_W-1:0]          dest_x_ff;
   logic [POS_W-1:0]          dest_y_ff;

   logic [COLOR_W-1:0] image_mem [PIXELS];

   // A stage takes a new word when it is empty or its word moves on.
   always_comb begin
      out_move       = !out_valid_ff || rsp_ready;
      move[STAGES]   = !valid_ff[STAGES] || out_move;
      for (int i = STAGES - 1; i >= 1; i--) begin
         move[i] = !valid_ff[i] || move[i+1];
      end
   end

   assign req_ready = move[1];

   assign item_in.cmd   = cmd_type'(req_command);
   assign item_in.pos_x = req_pos_x;
   assign item_in.pos_y = req_pos_y;
   assign item_in.color = req_load_color;

   // Frame advance on acceptance: step the frame and the zoom, or wrap to the start.
   always_comb begin
      cycle_len      = (cycle_length_ff == '0 || cycle_length_ff > CYCLE_MAX) ?
                       CYCLE_MAX : cycle_length_ff;
      frame_next     = {1'b0, frame_ff} + CYCLE_W'(1);
      zoom_dec       = zoom_ff - signed'(ZOOM_W'(scale_step_ff));
      advance_accept = req_valid && move[1] && (item_in.cmd == CMD_ADVANCE);
      if (frame_next >= cycle_len) begin
         frame_in = '0;
         zoom_in  = ZOOM_ONE;
      end else begin
         frame_in = frame_next[FRAME_W-1:0];
         zoom_in  = (zoom_dec < ZOOM_MIN) ? ZOOM_MIN : zoom_dec;
      end
   end

   // Stage one to two: table products and centred offsets.
   assign angle_cos1 = signed'(ANGLE_COS[frame1_ff]);
   assign angle_sin1 = signed'(ANGLE_SIN[frame1_ff]);
   assign pcos_in    = zoom1_ff * angle_cos1;
   assign psin_in    = zoom1_ff * angle_sin1;
   assign dx_in      = signed'({1'b0, item_ff[1].pos_x}) - CENTER_D;
   assign dy_in      = signed'({1'b0, item_ff[1].pos_y}) - CENTER_D;

   // Stage two to three: coefficients rounded half away from zero.
   assign rnd_cos      = pcos2_ff + (pcos2_ff[PROD_W-1] ? ROUND_HALF_M1 : ROUND_HALF);
   assign rnd_sin      = psin2_ff + (psin2_ff[PROD_W-1] ? ROUND_HALF_M1 : ROUND_HALF);
   assign coeff_cos_in = COEFF_W'(rnd_cos >>> ROUND_SH);
   assign coeff_sin_in = COEFF_W'(rnd_sin >>> ROUND_SH);
   assign coeff_load   = move[3] && valid_ff[2] && (item_ff[2].cmd == CMD_ADVANCE);

   // Stage three to four: source coordinates in fixed point.
   assign sum_x_in = SUM_W'(mxc3_ff) - SUM_W'(mys3_ff) + OFFSET;
   assign sum_y_in = SUM_W'(mxs3_ff) + SUM_W'(myc3_ff) + OFFSET;

   // Stage four to five: truncation toward zero; loads take their own position.
   assign trunc_x = sum_x4_ff + (sum_x4_ff[SUM_W-1] ? TRUNC_BIAS : '0);
   assign trunc_y = sum_y4_ff + (sum_y4_ff[SUM_W-1] ? TRUNC_BIAS : '0);

   always_comb begin
      if (item_ff[4].cmd == CMD_SAMPLE) begin
         col_in = INT_W'(trunc_x >>> COEFF_FRAC_BITS);
         row_in = INT_W'(trunc_y >>> COEFF_FRAC_BITS);
      end else begin
         col_in = signed'(INT_W'(item_ff[4].pos_x));
         row_in = signed'(INT_W'(item_ff[4].pos_y));
      end
   end

   // Stage five to six: screen bounds and store address.
   assign inside_in = (col5_ff >= 0) && (col5_ff < SIZE_I) &&
                      (row5_ff >= 0) && (row5_ff < SIZE_I);
   assign addr_in   = ADDR_W'(row5_ff[POS_W-1:0] * SCREEN_SIZE) +
                      ADDR_W'(col5_ff[POS_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_length_ff <= CYCLE_LENGTH_RST;
         scale_step_ff   <= SCALE_STEP_RST;
         frame_ff        <= '0;
         zoom_ff         <= ZOOM_ONE;
         coeff_cos_ff    <= COEFF_ONE;
         coeff_sin_ff    <= '0;
         valid_ff        <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_CYCLE_LENGTH: cycle_length_ff <= csr_wdata[CYCLE_W-1:0];
               CSR_SCALE_STEP:   scale_step_ff   <= csr_wdata[STEP_W-1:0];
            endcase
         end
         if (advance_accept) begin
            frame_ff <= frame_in;
            zoom_ff  <= zoom_in;
         end
         if (coeff_load) begin
            coeff_cos_ff <= coeff_cos_in;
            coeff_sin_ff <= coeff_sin_in;
         end
         if (move[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int i = 2; i <= STAGES; i++) begin
            if (move[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
         if (out_move) begin
            out_valid_ff <= valid_ff[STAGES] && (item_ff[STAGES].cmd == CMD_SAMPLE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move[1]) begin
         item_ff[1] <= item_in;
         frame1_ff  <= frame_in;
         zoom1_ff   <= zoom_in;
      end
      for (int i = 2; i <= STAGES; i++) begin
         if (move[i]) begin
            item_ff[i] <= item_ff[i-1];
         end
      end
      if (move[2]) begin
         pcos2_ff <= pcos_in;
         psin2_ff <= psin_in;
         dx2_ff   <= dx_in;
         dy2_ff   <= dy_in;
      end
      if (move[3]) begin
         mxc3_ff <= dx2_ff * coeff_cos_ff;
         mys3_ff <= dy2_ff * coeff_sin_ff;
         mxs3_ff <= dx2_ff * coeff_sin_ff;
         myc3_ff <= dy2_ff * coeff_cos_ff;
      end
      if (move[4]) begin
         sum_x4_ff <= sum_x_in;
         sum_y4_ff <= sum_y_in;
      end
      if (move[5]) begin
         col5_ff <= col_in;
         row5_ff <= row_in;
      end
      if (move[6]) begin
         inside6_ff <= inside_in;
         addr6_ff   <= addr_in;
      end
      if (out_move) begin
         inside_out_ff <= inside6_ff;
         dest_x_ff     <= item_ff[STAGES].pos_x;
         dest_y_ff     <= item_ff[STAGES].pos_y;
      end
   end

   // Source image store: one write and one registered read per cycle while the last stage moves on.
   always_ff @(posedge clock) begin
      if (out_move && valid_ff[STAGES] && inside6_ff &&
          (item_ff[STAGES].cmd == CMD_LOAD)) begin
         image_mem[addr6_ff] <= item_ff[STAGES].color;
      end
      if (out_move) begin
         read_color_ff <= image_mem[addr6_ff];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_dest_x      = dest_x_ff;
   assign rsp_dest_y      = dest_y_ff;
   assign rsp_pixel_color = inside_out_ff ? read_color_ff : '0;

endmodule

/* rtl/rzps_checker.sv */
// Port-level checks of the rotate-and-zoom sampler, bound to its top level.
// Depends on rzps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rzps_checker
   import rzps_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [POS_W-1:0]   rsp_dest_x,
   input logic [POS_W-1:0]   rsp_dest_y,
   input logic [COLOR_W-1:0] rsp_pixel_color
);

   // A stalled result word keeps its fields.
   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_x) && $stable(rsp_dest_y)
         && $stable(rsp_pixel_color);
   endproperty

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, p_rsp_hold, "result word changed while stalled")

   // Reset empties the output register.
   `ASSERT_CLK(a_rsp_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // After reset every stage is empty, so a word can be taken.
   `ASSERT_CLK(a_req_after_reset, clock, $past(reset) |-> req_ready, "not ready after reset")

   // A free output lets the whole pipeline move, so the input is not blocked while rsp_ready is high.
   `ASSERT_CLK(a_ready_chain, clock, rsp_ready |-> req_ready, "input blocked while output free")

endmodule

bind rotate_zoom_pixel_sampler rzps_checker u_rzps_checker (.*);
